// ===== rtl/core/lpht_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // The table size must be a power of two: the home slot is the low bits of the key.
    localparam int TABLE_SIZE = 256;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int ENTRY_W    = 9;

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);

    localparam int S_TDATA_W = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + ENTRY_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_KEY_ZERO  = 2'd3
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic advance;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: stream ports, controller and datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash table of TABLE_SIZE slots with linear probing. Each input
// word is a lookup (opcode 0) or a store/update (opcode 1) of a nonzero key; each
// gives exactly one result word with a status, the value found by a lookup, and
// the entry count after the request. A request probes N slots (1 to TABLE_SIZE):
// the slot memories have one read port and the probe visits one slot per cycle,
// starting at the key's low bits and wrapping at the end of the table. Key
// zero is rejected at the first probe. The next word is accepted as soon as the
// previous one retires into the output register, even while that result waits
// for m_tready. Slot occupancy is kept in per-slot valid flops, so the table is
// empty right after reset with no sweep.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // key, value
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // opcode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // found_value, entry_count, zero pad
    output logic [M_TUSER_W-1:0]      m_tuser    // status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    lpht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpht_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lpht_ctrl.sv =====
// Request sequencer of the hash table: accepts a word, steps the probe, retires it.
// Depends on lpht_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                // A finished probe holds here until the output register is free.
                cmd.advance = !sts.done;
                cmd.finish  = sts.done && sts.out_free;
                if (sts.done && sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lpht_dp.sv =====
// Datapath of the hash table: slot memories, valid bits, entry count, output register.
// Depends on lpht_pkg; driven by lpht_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp
    import lpht_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser
);

    logic [KEY_W-1:0]   key_mem [TABLE_SIZE];
    logic [VALUE_W-1:0] val_mem [TABLE_SIZE];
    logic               valid_reg [TABLE_SIZE];

    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [ADDR_W-1:0]  probe_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [KEY_W-1:0]   rd_key_reg;
    logic [VALUE_W-1:0] rd_val_reg;
    logic               rd_vld_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [VALUE_W-1:0] out_found_reg;
    logic [ENTRY_W-1:0] out_count_reg;

    logic [KEY_W-1:0]   in_key;
    logic [VALUE_W-1:0] in_val;
    logic [ADDR_W-1:0]  pos_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic               key_zero;
    logic               is_store;
    logic               hit;
    logic               empty;
    logic               last_probe;
    logic               wr_key;
    logic               wr_val;
    status_t            res_status;
    logic [VALUE_W-1:0] res_found;

    assign in_key = s_tdata[KEY_W-1:0];
    assign in_val = s_tdata[KEY_W+VALUE_W-1:KEY_W];

    assign pos_inc = (pos_reg == ADDR_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + 1'b1;

    // The read address is the slot that pos_reg holds in the next cycle, so the
    // registered read data always belongs to the current probe position.
    always_comb begin
        if (cmd.load) begin
            rd_addr = in_key[ADDR_W-1:0];
        end else if (cmd.advance) begin
            rd_addr = pos_inc;
        end else begin
            rd_addr = pos_reg;
        end
    end

    // Stored keys are never zero, so an invalid slot is exactly an empty one.
    assign key_zero   = (key_reg == '0);
    assign is_store   = (op_reg == OP_STORE);
    assign hit        = rd_vld_reg && (rd_key_reg == key_reg);
    assign empty      = !rd_vld_reg;
    assign last_probe = (probe_reg == ADDR_W'(TABLE_SIZE - 1));

    always_comb begin
        res_found = '0;
        if (key_zero) begin
            res_status = ST_KEY_ZERO;
        end else if (hit) begin
            res_status = ST_OK;
            if (!is_store) begin
                res_found = rd_val_reg;
            end
        end else if (empty) begin
            res_status = is_store ? ST_OK : ST_NOT_FOUND;
        end else begin
            res_status = ST_FULL;
        end
    end

    assign wr_val     = cmd.finish && !key_zero && is_store && (hit || empty);
    assign wr_key     = cmd.finish && !key_zero && is_store && !hit && empty;
    assign count_next = count_reg + CNT_W'(wr_key);

    assign sts.done     = key_zero || hit || empty || last_probe;
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser[0];
            key_reg <= in_key;
            val_reg <= in_val;
        end
        if (cmd.load) begin
            pos_reg   <= in_key[ADDR_W-1:0];
            probe_reg <= '0;
        end else if (cmd.advance) begin
            pos_reg   <= pos_inc;
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.finish) begin
            out_status_reg <= res_status;
            out_found_reg  <= res_found;
            out_count_reg  <= ENTRY_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_key) begin
            key_mem[pos_reg] <= key_reg;
        end
        if (wr_val) begin
            val_mem[pos_reg] <= val_reg;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                valid_reg[i] <= 1'b0;
            end
            rd_vld_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (wr_key) begin
                valid_reg[pos_reg] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
            count_reg  <= count_next;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_found_reg});

    // A new result must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while a word was pending");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && (cmd.advance || cmd.finish)) && !(cmd.advance && cmd.finish))
        else $error("conflicting datapath commands");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_SIZE))
        else $error("entry count exceeds table size");

    a_claim_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_key |=> (count_reg == $past(count_reg) + 1'b1) && valid_reg[$past(pos_reg)])
        else $error("claimed slot not counted or not marked valid");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for linear_probe_hash_table: a request driver, a result monitor
// and a shadow copy of the slot table that predicts every reply.
// Depends on lpht_pkg and the RTL of linear_probe_hash_table only.
`timescale 1ns / 1ps

module tb;
    import lpht_pkg::*;

    typedef struct {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        int unsigned         gap;
    } request_t;

    typedef struct {
        status_t             status;
        logic [VALUE_W-1:0]  found;
        logic [ENTRY_W-1:0]  count;
    } reply_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    linear_probe_hash_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // key, value
        .s_tuser  (s_tuser),    // opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // found_value, entry_count, zero pad
        .m_tuser  (m_tuser)     // status
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Shadow copy of the table, updated in acceptance order.
    logic [KEY_W-1:0]   shadow_key [TABLE_SIZE];
    logic [VALUE_W-1:0] shadow_val [TABLE_SIZE];
    int unsigned        shadow_count = 0;

    request_t           request_queue[$];
    reply_t             expected_replies[$];
    logic [KEY_W-1:0]   stored_keys[$];

    int  mismatches      = 0;
    int  requests_sent   = 0;
    int  replies_checked = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  tx_quiet        = 1'b0;
    bit  rx_quiet        = 1'b0;
    logic [ADDR_W-1:0] cluster_base = '0;

    function automatic reply_t apply_to_shadow_table(request_t rq);
        reply_t      rp;
        int unsigned slot;
        int unsigned probes;
        bit          settled;
        rp.status = ST_FULL;
        rp.found  = '0;
        settled   = (rq.key == '0);
        if (settled)
            rp.status = ST_KEY_ZERO;
        slot   = rq.key % TABLE_SIZE;
        probes = 0;
        while (!settled && probes < TABLE_SIZE) begin
            if (shadow_key[slot] == rq.key) begin
                if (rq.op == OP_STORE)
                    shadow_val[slot] = rq.value;
                else
                    rp.found = shadow_val[slot];
                rp.status = ST_OK;
                settled   = 1'b1;
            end else if (shadow_key[slot] == '0) begin
                if (rq.op == OP_STORE) begin
                    shadow_key[slot] = rq.key;
                    shadow_val[slot] = rq.value;
                    shadow_count++;
                    rp.status = ST_OK;
                end else begin
                    rp.status = ST_NOT_FOUND;
                end
                settled = 1'b1;
            end
            slot = (slot + 1) % TABLE_SIZE;
            probes++;
        end
        rp.count = ENTRY_W'(shadow_count);
        return rp;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("ERROR %0t ns: reply %0d %s: got %0h, expected %0h",
                 $time, replies_checked, what, got, want);
    endtask

    // Driver: each word waits out its own gap after it has been accepted.
    request_t    cur_request;
    int unsigned idle_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            idle_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(apply_to_shadow_table(cur_request));
                requests_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (idle_left != 0) begin
                    s_tvalid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (request_queue.size() != 0) begin
                    cur_request = request_queue.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= S_TDATA_W'({cur_request.value, cur_request.key});
                    s_tuser   <= cur_request.op;
                    idle_left <= cur_request.gap;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted reply against the oldest prediction.
    int unsigned stall_left = 0;

    always @(posedge aclk) begin : monitor
        reply_t      want;
        int unsigned stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected word", 64'(m_tdata), 64'(0));
            end else begin
                want = expected_replies.pop_front();
                if (status_t'(m_tuser) != want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[VALUE_W-1:0] != want.found)
                    report_mismatch("found_value", 64'(m_tdata[VALUE_W-1:0]), 64'(want.found));
                if (m_tdata[VALUE_W +: ENTRY_W] != want.count)
                    report_mismatch("entry_count", 64'(m_tdata[VALUE_W +: ENTRY_W]),
                                    64'(want.count));
                if (m_tdata[M_TDATA_W-1:VALUE_W+ENTRY_W] != '0)
                    report_mismatch("pad bits", 64'(m_tdata[M_TDATA_W-1:VALUE_W+ENTRY_W]),
                                    64'(0));
                status_seen[want.status]++;
            end
            replies_checked++;
            if (replies_checked % 64 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            m_tready   <= (stall == 0);
            stall_left <= stall;
        end else if (stall_left != 0) begin
            m_tready   <= (stall_left == 1);
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_request(input logic op, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] value);
        request_t rq;
        rq.op    = op;
        rq.key   = key;
        rq.value = value;
        rq.gap   = tx_quiet ? 0 : $urandom_range(0, 15);
        request_queue.push_back(rq);
        if (op == OP_STORE && key != '0)
            stored_keys.push_back(key);
    endtask

    // Mix of known keys, zero keys, and fresh keys that are clustered near one home
    // slot, have a single bit set, or are fully random.
    task automatic queue_mixed_request(input int known_pct, input int store_new_pct);
        int               sel;
        logic [KEY_W-1:0] key;
        logic             op;
        sel = $urandom_range(0, 99);
        op  = ($urandom_range(0, 99) < store_new_pct) ? OP_STORE : OP_LOOKUP;
        key = $urandom();
        if (sel < known_pct) begin
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            op  = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
        end else if (sel < known_pct + 5) begin
            key = '0;
            op  = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
        end else if (sel < known_pct + 30) begin
            key[ADDR_W-1:0] = cluster_base + ADDR_W'($urandom_range(0, 11));
        end else if (sel < known_pct + 40) begin
            key = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
        end
        queue_request(op, key, $urandom());
    endtask

    // Polled on the falling edge so that the driver's hand-off has settled.
    task automatic wait_drained();
        while (request_queue.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        int i;
        int fill;
        foreach (shadow_key[j]) begin
            shadow_key[j] = '0;
            shadow_val[j] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: key zero, misses on an empty table, updates, extreme keys and
        // values, and a collision chain that wraps from the last slot to slot 0.
        queue_request(OP_LOOKUP, '0, '0);
        queue_request(OP_STORE, '0, '1);
        queue_request(OP_LOOKUP, 1, '0);
        queue_request(OP_STORE, 1, '0);
        queue_request(OP_LOOKUP, 1, '0);
        queue_request(OP_STORE, 1, '1);
        queue_request(OP_LOOKUP, 1, '0);
        queue_request(OP_STORE, '1, 32'hA5A5_A5A5);
        queue_request(OP_STORE, KEY_W'(2 * TABLE_SIZE - 1), 32'h0000_0001);
        queue_request(OP_STORE, KEY_W'(TABLE_SIZE), 32'h8000_0000);
        queue_request(OP_LOOKUP, KEY_W'(TABLE_SIZE), '0);
        queue_request(OP_LOOKUP, KEY_W'(2 * TABLE_SIZE - 1), '0);
        queue_request(OP_LOOKUP, KEY_W'(2 * TABLE_SIZE), '0);
        queue_request(OP_LOOKUP, '1, '0);
        queue_request(OP_STORE, 32'h8000_0000, 32'h5A5A_5A5A);
        queue_request(OP_LOOKUP, 32'h8000_0000, '1);
        queue_request(OP_STORE, '1, 32'h0000_0001);
        queue_request(OP_LOOKUP, '1, '0);
        queue_request(OP_STORE, '0, '0);

        // Random traffic at moderate load, with clusters that move around the table.
        for (i = 0; i < 800; i++) begin
            if (i % 50 == 0)
                cluster_base = $urandom_range(0, 1) ? ADDR_W'(TABLE_SIZE - 10)
                                                    : ADDR_W'($urandom());
            if (i % 100 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            queue_mixed_request(35, 35);
        end
        wait_drained();

        // Fill every free slot, then push a few more stores that must find it full.
        tx_quiet = 1'b0;
        fill = TABLE_SIZE - shadow_count + 20;
        for (i = 0; i < fill; i++)
            queue_request(OP_STORE, KEY_W'($urandom()) | KEY_W'(1), $urandom());
        wait_drained();

        // Full table: hits and updates still work, misses and new keys report full.
        for (i = 0; i < 400; i++) begin
            if (i % 40 == 0)
                cluster_base = ADDR_W'($urandom());
            if (i % 100 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            queue_mixed_request(45, 50);
        end
        wait_drained();
        repeat (2 * TABLE_SIZE + 16) @(negedge aclk);

        $display("Ran %0d requests against %0d replies: %0d ok, %0d not found,",
                 requests_sent, replies_checked, status_seen[ST_OK],
                 status_seen[ST_NOT_FOUND]);
        $display("%0d full, %0d key zero; table ended with %0d of %0d slots occupied.",
                 status_seen[ST_FULL], status_seen[ST_KEY_ZERO], shadow_count, TABLE_SIZE);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timeout with %0d requests queued and %0d replies outstanding.",
                 request_queue.size(), expected_replies.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== linear_probe_hash_table.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_ctrl.sv
rtl/core/lpht_dp.sv
rtl/core/linear_probe_hash_table.sv
tb/tb.sv
